FILE: sv/etfi_pkg.sv
// Package for the escape-time fractal iterator.
// Holds fixed widths, register codes, reset values and the shared types.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package etfi_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 28;
  localparam int MAG_W      = COORD_W + 4;
  localparam int ITER_W     = 16;
  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int STEP_W     = 31;
  localparam int LIM_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

  localparam logic [COORD_W-1:0] CENTER_RE_RST = 32'hF800_0000;
  localparam logic [COORD_W-1:0] CENTER_IM_RST = '0;
  localparam logic [STEP_W-1:0]  STEP_RST      = 31'h4000_0000;
  localparam logic [DIM_W-1:0]   DIM_RST       = DIM_W'(1);
  localparam logic [ITER_W-1:0]  MAX_ITER_RST  = ITER_W'(8192);
  localparam logic [LIM_W-1:0]   ESC_LIM_RST   = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_RE  = 3'd0,
    REG_CENTER_IM  = 3'd1,
    REG_PIXEL_STEP = 3'd2,
    REG_WIDTH      = 3'd3,
    REG_HEIGHT     = 3'd4,
    REG_MAX_ITER   = 3'd5,
    REG_JULIA      = 3'd6,
    REG_ESC_LIMIT  = 3'd7
  } cfg_addr_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_re;
    logic signed [COORD_W-1:0] center_im;
    logic [STEP_W-1:0]         pixel_step;
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
    logic [ITER_W-1:0]         max_iterations;
    logic                      julia_mode;
    logic [LIM_W-1:0]          escape_limit_sq;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_LOAD,
    ST_ITER,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic map;
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/etfi_regs.sv
// Configuration register file of the fractal iterator.
// Depends on etfi_pkg for register codes, widths and reset values.
`default_nettype none

module etfi_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [etfi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [etfi_pkg::CFG_DATA_W-1:0]      cfg_data,
  output etfi_pkg::cfg_t                            cfg
);

  etfi_pkg::cfg_t cfg_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid && cfg_ready) begin
      unique case (etfi_pkg::cfg_addr_t'(cfg_index))
        etfi_pkg::REG_CENTER_RE:  cfg_next.center_re = $signed(cfg_data[etfi_pkg::COORD_W-1:0]);
        etfi_pkg::REG_CENTER_IM:  cfg_next.center_im = $signed(cfg_data[etfi_pkg::COORD_W-1:0]);
        etfi_pkg::REG_PIXEL_STEP: cfg_next.pixel_step = cfg_data[etfi_pkg::STEP_W-1:0];
        etfi_pkg::REG_WIDTH:      cfg_next.width = cfg_data[etfi_pkg::DIM_W-1:0];
        etfi_pkg::REG_HEIGHT:     cfg_next.height = cfg_data[etfi_pkg::DIM_W-1:0];
        etfi_pkg::REG_MAX_ITER:   cfg_next.max_iterations = cfg_data[etfi_pkg::ITER_W-1:0];
        etfi_pkg::REG_JULIA:      cfg_next.julia_mode = cfg_data[0];
        etfi_pkg::REG_ESC_LIMIT:  cfg_next.escape_limit_sq = cfg_data[etfi_pkg::LIM_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_re       <= $signed(etfi_pkg::CENTER_RE_RST);
      cfg.center_im       <= $signed(etfi_pkg::CENTER_IM_RST);
      cfg.pixel_step      <= etfi_pkg::STEP_RST;
      cfg.width           <= etfi_pkg::DIM_RST;
      cfg.height          <= etfi_pkg::DIM_RST;
      cfg.max_iterations  <= etfi_pkg::MAX_ITER_RST;
      cfg.julia_mode      <= 1'b0;
      cfg.escape_limit_sq <= etfi_pkg::ESC_LIM_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/etfi_ctrl.sv
// Sequencer of the fractal iterator: pixel handshake, step commands, result slot.
// Depends on etfi_pkg for the state, command and status types.
`default_nettype none

module etfi_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pixel_valid,
  output logic                    pixel_stall,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output etfi_pkg::dp_cmd_t       cmd,
  input  wire etfi_pkg::dp_stat_t stat
);

  etfi_pkg::ctrl_state_t state, state_next;
  logic                  res_valid, res_valid_next;
  logic                  slot_free;

  assign slot_free    = !res_valid || !result_stall;
  assign pixel_stall  = (state != etfi_pkg::ST_IDLE);
  assign result_valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= etfi_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      etfi_pkg::ST_IDLE: begin
        if (pixel_valid) begin
          cmd.take   = 1'b1;
          state_next = etfi_pkg::ST_MAP;
        end
      end
      etfi_pkg::ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = etfi_pkg::ST_LOAD;
      end
      etfi_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = etfi_pkg::ST_ITER;
      end
      etfi_pkg::ST_ITER: begin
        if (!stat.stop) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = etfi_pkg::ST_IDLE;
        end else begin
          state_next = etfi_pkg::ST_HOLD;
        end
      end
      etfi_pkg::ST_HOLD: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = etfi_pkg::ST_IDLE;
        end
      end
      default: state_next = etfi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (cmd.emit) begin
      res_valid_next = 1'b1;
    end else if (res_valid && !result_stall) begin
      res_valid_next = 1'b0;
    end
  end

  a_take_starts_map: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> (state == etfi_pkg::ST_MAP))
    else $error("accepted pixel did not start mapping");

  a_step_emit_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && cmd.emit))
    else $error("step and emit issued together");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> result_valid)
    else $error("emitted word not presented");

endmodule

`default_nettype wire

FILE: sv/etfi_dp.sv
// Datapath of the fractal iterator: pixel mapping, z update, escape test, result register.
// Depends on etfi_pkg for widths and the configuration, command and status types.
`default_nettype none

module etfi_dp (
  input  wire logic                             clk,
  input  wire etfi_pkg::cfg_t                   cfg,
  input  wire etfi_pkg::dp_cmd_t                cmd,
  output etfi_pkg::dp_stat_t                    stat,
  input  wire logic [etfi_pkg::PIX_W-1:0]       pixel_x,
  input  wire logic [etfi_pkg::PIX_W-1:0]       pixel_y,
  output logic [etfi_pkg::ITER_W-1:0]           iterations,
  output logic [etfi_pkg::MAG_W-1:0]            magnitude_sq,
  output logic                                  escaped
);

  localparam int CW     = etfi_pkg::COORD_W;
  localparam int FW     = etfi_pkg::FRAC_W;
  localparam int D_W    = etfi_pkg::PIX_W + 3;
  localparam int MP_W   = etfi_pkg::STEP_W + 1 + D_W;
  localparam int MS_W   = MP_W + 1;
  localparam int PROD_W = 2 * CW;
  localparam int SH_W   = PROD_W - FW;
  localparam int SUM_W  = SH_W + 2;
  localparam int MRAW_W = PROD_W + 1 - FW;
  localparam int SAT_W  = (MS_W > SUM_W) ? MS_W : SUM_W;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    logic hi_ones;
    logic hi_zero;
    hi_ones = &v[SAT_W-1:CW-1];
    hi_zero = ~|v[SAT_W-1:CW-1];
    if (hi_ones || hi_zero) begin
      return $signed(v[CW-1:0]);
    end else if (v[SAT_W-1]) begin
      return $signed({1'b1, {(CW-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(CW-1){1'b1}}});
    end
  endfunction

  logic [etfi_pkg::PIX_W-1:0]  px, py;
  logic signed [MP_W-1:0]      map_re, map_im;
  logic signed [CW-1:0]        z_re, z_im, c_re, c_im;
  logic [etfi_pkg::ITER_W-1:0] cnt;

  logic [etfi_pkg::DIM_W-1:0]  w_eff, h_eff;
  logic signed [D_W-1:0]       d_re, d_im;
  logic signed [MP_W-1:0]      m_re, m_im;
  logic signed [MS_W-1:0]      pr_sum, pi_sum;
  logic signed [CW-1:0]        p_re, p_im;

  logic signed [PROD_W-1:0]    p_rr, p_ii, p_ri;
  logic signed [SH_W-1:0]      s_rr, s_ii, s_ri;
  logic signed [SUM_W-1:0]     sum_re, sum_im;
  logic [PROD_W:0]             mag_sum;
  logic [MRAW_W-1:0]           mag_raw;
  logic [etfi_pkg::MAG_W-1:0]  mag_cur;
  logic                        over, first;

  // pixel to complex plane
  always_comb begin
    w_eff  = (cfg.width  > etfi_pkg::MAX_DIM) ? etfi_pkg::MAX_DIM : cfg.width;
    h_eff  = (cfg.height > etfi_pkg::MAX_DIM) ? etfi_pkg::MAX_DIM : cfg.height;
    d_re   = $signed({2'b00, px, 1'b1}) - $signed({2'b00, w_eff});
    d_im   = $signed({2'b00, py, 1'b1}) - $signed({2'b00, h_eff});
    m_re   = $signed({1'b0, cfg.pixel_step}) * d_re;
    m_im   = $signed({1'b0, cfg.pixel_step}) * d_im;
    pr_sum = MS_W'(cfg.center_re) + MS_W'(map_re >>> 1);
    pi_sum = MS_W'(cfg.center_im) - MS_W'(map_im >>> 1);
    p_re   = sat_coord(SAT_W'(pr_sum));
    p_im   = sat_coord(SAT_W'(pi_sum));
  end

  // one iteration of z*z + c, plus |z|^2 of the current z
  always_comb begin
    p_rr    = z_re * z_re;
    p_ii    = z_im * z_im;
    p_ri    = z_re * z_im;
    s_rr    = $signed(p_rr[PROD_W-1:FW]);
    s_ii    = $signed(p_ii[PROD_W-1:FW]);
    s_ri    = $signed(p_ri[PROD_W-1:FW]);
    sum_re  = SUM_W'(s_rr) - SUM_W'(s_ii) + SUM_W'(c_re);
    sum_im  = (SUM_W'(s_ri) <<< 1) + SUM_W'(c_im);
    mag_sum = {1'b0, p_rr} + {1'b0, p_ii};
    mag_raw = mag_sum[PROD_W:FW];
    mag_cur = (|mag_raw[MRAW_W-1:etfi_pkg::MAG_W]) ? '1 : mag_raw[etfi_pkg::MAG_W-1:0];
    first   = (cnt == '0);
    over    = !first && (mag_cur > etfi_pkg::MAG_W'(cfg.escape_limit_sq));
    stat.stop = (cnt >= cfg.max_iterations) || over;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.map) begin
      map_re <= m_re;
      map_im <= m_im;
    end
    if (cmd.load) begin
      cnt <= '0;
      if (cfg.julia_mode) begin
        z_re <= p_re;
        z_im <= p_im;
        c_re <= cfg.center_re;
        c_im <= cfg.center_im;
      end else begin
        z_re <= '0;
        z_im <= '0;
        c_re <= p_re;
        c_im <= p_im;
      end
    end else if (cmd.step) begin
      z_re <= sat_coord(SAT_W'(sum_re));
      z_im <= sat_coord(SAT_W'(sum_im));
      cnt  <= cnt + 1'b1;
    end
    if (cmd.emit) begin
      iterations   <= cnt;
      magnitude_sq <= first ? '0 : mag_cur;
      escaped      <= over;
    end
  end

endmodule

`default_nettype wire

FILE: sv/escape_time_fractal_iterator.sv
// Top level of the escape-time fractal iterator (Mandelbrot / Julia, Q4.28).
// Depends on etfi_pkg, etfi_regs, etfi_ctrl and etfi_dp.
//
//   channel   direction  handshake                  payload
//   pixel     in         pixel_valid / pixel_stall  pixel_x, pixel_y
//   result    out        result_valid / result_stall iterations, magnitude_sq, escaped
//   cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// From acceptance to the next acceptance, a pixel passes these steps in order:
// the pixel is mapped, z and c are loaded, then the z register loop runs one
// iteration per cycle through its three multipliers, and the final z is tested.
// Reset (rst, synchronous) restores the register defaults and drops a pixel in flight.
// The result sits in an output register; a new pixel is taken while it waits, and
// the loop holds its finished result only when that register is still occupied.
`default_nettype none

module escape_time_fractal_iterator (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 pixel_valid,
  output logic                                      pixel_stall,
  input  wire logic [etfi_pkg::PIX_W-1:0]           pixel_x,
  input  wire logic [etfi_pkg::PIX_W-1:0]           pixel_y,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic [etfi_pkg::ITER_W-1:0]               iterations,
  output logic [etfi_pkg::MAG_W-1:0]                magnitude_sq,
  output logic                                      escaped,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [etfi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [etfi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  etfi_pkg::cfg_t     cfg;
  etfi_pkg::dp_cmd_t  cmd;
  etfi_pkg::dp_stat_t stat;

  etfi_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  etfi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  etfi_dp u_dp (
    .clk          (clk),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .iterations   (iterations),
    .magnitude_sq (magnitude_sq),
    .escaped      (escaped)
  );

endmodule

`default_nettype wire

FILE: tb/etfi_result_check.sv
// Result checker for the escape-time fractal iterator.
// Tracks the register writes, predicts each pixel's escape result and compares the
// result words in order. Depends on etfi_pkg.
module etfi_result_check (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pixel_valid,
  input  wire logic                              pixel_stall,
  input  wire logic [etfi_pkg::PIX_W-1:0]        pixel_x,
  input  wire logic [etfi_pkg::PIX_W-1:0]        pixel_y,
  input  wire logic                              result_valid,
  input  wire logic                              result_stall,
  input  wire logic [etfi_pkg::ITER_W-1:0]       iterations,
  input  wire logic [etfi_pkg::MAG_W-1:0]        magnitude_sq,
  input  wire logic                              escaped,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [etfi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [etfi_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                     mismatches,
  output int                                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [etfi_pkg::ITER_W-1:0] iterations;
    logic [etfi_pkg::MAG_W-1:0]  magnitude_sq;
    logic                        escaped;
  } escape_result_t;

  localparam longint COORD_HI = (longint'(1) <<< (etfi_pkg::COORD_W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  etfi_pkg::cfg_t view;
  longint         z_re, z_im, c_re, c_im;
  int unsigned    loop_count;
  escape_result_t pending_escapes[$];

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic longint pixel_offset(logic [etfi_pkg::PIX_W-1:0] pix,
                                          logic [etfi_pkg::DIM_W-1:0] dim);
    longint span;
    longint d;
    span = (dim > etfi_pkg::MAX_DIM) ? longint'(etfi_pkg::MAX_DIM) : longint'(dim);
    d = 2 * longint'(pix) + 1 - span;
    return (longint'(view.pixel_step) * d) >>> 1;
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    return (a * b) >>> etfi_pkg::FRAC_W;
  endfunction

  function automatic logic [etfi_pkg::MAG_W-1:0] magnitude_of(longint re, longint im);
    logic [64:0] acc;
    acc = {1'b0, re * re} + {1'b0, im * im};
    acc = acc >> etfi_pkg::FRAC_W;
    if (acc[64:etfi_pkg::MAG_W] != '0) return '1;
    return acc[etfi_pkg::MAG_W-1:0];
  endfunction

  function automatic escape_result_t iterate_pixel(logic [etfi_pkg::PIX_W-1:0] px,
                                                   logic [etfi_pkg::PIX_W-1:0] py);
    longint         centre_re;
    longint         centre_im;
    longint         pr;
    longint         pi;
    longint         nr;
    longint         ni;
    logic [etfi_pkg::MAG_W-1:0] mag;
    escape_result_t r;
    centre_re = $signed(view.center_re);
    centre_im = $signed(view.center_im);
    pr = clamp_coord(centre_re + pixel_offset(px, view.width));
    pi = clamp_coord(centre_im - pixel_offset(py, view.height));
    if (view.julia_mode) begin
      z_re = pr;
      z_im = pi;
      c_re = centre_re;
      c_im = centre_im;
    end else begin
      z_re = 0;
      z_im = 0;
      c_re = pr;
      c_im = pi;
    end
    mag = '0;
    loop_count = 0;
    while (loop_count < view.max_iterations && mag <= view.escape_limit_sq) begin
      nr = clamp_coord(fix_mul(z_re, z_re) - fix_mul(z_im, z_im) + c_re);
      ni = clamp_coord(2 * fix_mul(z_re, z_im) + c_im);
      z_re = nr;
      z_im = ni;
      mag = magnitude_of(nr, ni);
      loop_count++;
    end
    r.iterations   = etfi_pkg::ITER_W'(loop_count);
    r.magnitude_sq = mag;
    r.escaped      = (mag > view.escape_limit_sq);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    escape_result_t want;
    if (rst) begin
      view.center_re       = etfi_pkg::CENTER_RE_RST;
      view.center_im       = etfi_pkg::CENTER_IM_RST;
      view.pixel_step      = etfi_pkg::STEP_RST;
      view.width           = etfi_pkg::DIM_RST;
      view.height          = etfi_pkg::DIM_RST;
      view.max_iterations  = etfi_pkg::MAX_ITER_RST;
      view.julia_mode      = 1'b0;
      view.escape_limit_sq = etfi_pkg::ESC_LIM_RST;
      z_re = 0;
      z_im = 0;
      c_re = 0;
      c_im = 0;
      loop_count = 0;
      pending_escapes.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_escapes.size() == 0) begin
          $display("%0t: result word with none expected: iterations %0d",
                   $time, iterations);
          $display("  magnitude_sq %0d escaped %0b", magnitude_sq, escaped);
          mismatches++;
        end else begin
          want = pending_escapes.pop_front();
          check_field("iterations", 64'(want.iterations), 64'(iterations));
          check_field("magnitude_sq", 64'(want.magnitude_sq), 64'(magnitude_sq));
          check_field("escaped", 64'(want.escaped), 64'(escaped));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (etfi_pkg::cfg_addr_t'(cfg_index))
          etfi_pkg::REG_CENTER_RE:  view.center_re       = cfg_data;
          etfi_pkg::REG_CENTER_IM:  view.center_im       = cfg_data;
          etfi_pkg::REG_PIXEL_STEP: view.pixel_step      = cfg_data[etfi_pkg::STEP_W-1:0];
          etfi_pkg::REG_WIDTH:      view.width           = cfg_data[etfi_pkg::DIM_W-1:0];
          etfi_pkg::REG_HEIGHT:     view.height          = cfg_data[etfi_pkg::DIM_W-1:0];
          etfi_pkg::REG_MAX_ITER:   view.max_iterations  = cfg_data[etfi_pkg::ITER_W-1:0];
          etfi_pkg::REG_JULIA:      view.julia_mode      = cfg_data[0];
          etfi_pkg::REG_ESC_LIMIT:  view.escape_limit_sq = cfg_data[etfi_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall)
        pending_escapes = {pending_escapes, iterate_pixel(pixel_x, pixel_y)};
    end
    outstanding = pending_escapes.size();
  end

endmodule

FILE: tb/tb_escape_time_fractal_iterator.sv
// Top of the escape-time fractal iterator testbench.
// Drives pixels, register writes and result back-pressure, and gives the verdict.
// Depends on etfi_pkg, escape_time_fractal_iterator and etfi_result_check.
module tb_escape_time_fractal_iterator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_OFF   = 300;
  localparam int SETTLE     = 8;

  logic                            clk;
  logic                            rst;
  logic                            pixel_valid;
  logic                            pixel_stall;
  logic [etfi_pkg::PIX_W-1:0]      pixel_x;
  logic [etfi_pkg::PIX_W-1:0]      pixel_y;
  logic                            result_valid;
  logic                            result_stall;
  logic [etfi_pkg::ITER_W-1:0]     iterations;
  logic [etfi_pkg::MAG_W-1:0]      magnitude_sq;
  logic                            escaped;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [etfi_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [etfi_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              mismatches;
  int                              outstanding;
  logic                            hold_go;
  int                              burst_left;

  escape_time_fractal_iterator DUT (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .result_valid(result_valid), .result_stall(result_stall),
    .iterations(iterations), .magnitude_sq(magnitude_sq), .escaped(escaped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  etfi_result_check u_result_check (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .result_valid(result_valid), .result_stall(result_stall),
    .iterations(iterations), .magnitude_sq(magnitude_sq), .escaped(escaped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic write_reg(input etfi_pkg::cfg_addr_t idx,
                           input logic [etfi_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [etfi_pkg::COORD_W-1:0] cr,
                           input logic [etfi_pkg::COORD_W-1:0] ci,
                           input logic [etfi_pkg::STEP_W-1:0] step,
                           input logic [etfi_pkg::DIM_W-1:0] w,
                           input logic [etfi_pkg::DIM_W-1:0] h,
                           input logic [etfi_pkg::ITER_W-1:0] iters,
                           input logic julia, input logic [etfi_pkg::LIM_W-1:0] lim);
    write_reg(etfi_pkg::REG_CENTER_RE, cr);
    write_reg(etfi_pkg::REG_CENTER_IM, ci);
    write_reg(etfi_pkg::REG_PIXEL_STEP, 32'(step));
    write_reg(etfi_pkg::REG_WIDTH, 32'(w));
    write_reg(etfi_pkg::REG_HEIGHT, 32'(h));
    write_reg(etfi_pkg::REG_MAX_ITER, 32'(iters));
    write_reg(etfi_pkg::REG_JULIA, 32'(julia));
    write_reg(etfi_pkg::REG_ESC_LIMIT, 32'(lim));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [etfi_pkg::PIX_W-1:0] x,
                            input logic [etfi_pkg::PIX_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pixel_valid <= 1'b1;
    pixel_x     <= x;
    pixel_y     <= y;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
  endtask

  // hold the sender back until every pixel has come out
  task automatic drain();
    pixel_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int span_left;
    int stall_pct;
    logic hold_done;
    span_left = 0;
    stall_pct = 0;
    hold_done = 1'b0;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_OFF) @(negedge clk);
      end
      if (span_left == 0) begin
        span_left = $urandom_range(10, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      span_left--;
      result_stall <= ($urandom_range(1, 100) <= stall_pct);
      @(negedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_escape_time_fractal_iterator: FAIL");
    $finish;
  end

  initial begin
    logic [etfi_pkg::COORD_W-1:0] cr;
    logic [etfi_pkg::COORD_W-1:0] ci;
    logic [etfi_pkg::STEP_W-1:0]  step;
    logic [etfi_pkg::DIM_W-1:0]   w;
    logic [etfi_pkg::DIM_W-1:0]   h;
    logic [etfi_pkg::ITER_W-1:0]  iters;
    logic [etfi_pkg::LIM_W-1:0]   lim;
    logic                         noisy;
    logic [etfi_pkg::PIX_W-1:0]   x;
    logic [etfi_pkg::PIX_W-1:0]   y;
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel_x = '0;
    pixel_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_go = 1'b0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset view: bounded centre point, then a pixel far outside the image
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();

    configure(32'd0, 32'd0, 31'd262144, 13'd4096, 13'd4096, 16'd64, 1'b0,
              etfi_pkg::ESC_LIM_RST);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'hAAA, 12'h555);
    drain();

    // Julia view; the corner pixel starts outside the escape radius
    configure(-32'sd214748365, 32'sd41875931, 31'd12582912, 13'd64, 13'd64, 16'd100, 1'b1,
              etfi_pkg::ESC_LIM_RST);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd31, 12'd31);
    send_pixel(12'd40, 12'd20);
    send_pixel(12'd63, 12'd0);
    drain();

    // saturating corner, zero width, oversized height, zero escape limit
    configure(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 13'd0, 13'd8191, 16'd3, 1'b0, 31'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();

    configure(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 13'd0, 13'd8191, 16'd0, 1'b1,
              31'h7FFF_FFFF);
    send_pixel(12'd5, 12'd9);
    drain();

    configure(32'd0, 32'd0, 31'h7FFF_FFFF, 13'd1, 13'd1, 16'hFFFF, 1'b0, 31'h7FFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      noisy = ($urandom_range(0, 4) == 0);
      w = etfi_pkg::DIM_W'($urandom_range(1, 4096));
      h = etfi_pkg::DIM_W'($urandom_range(1, 4096));
      if (noisy) begin
        cr = $urandom;
        ci = $urandom;
        step = etfi_pkg::STEP_W'($urandom_range(1, 32'h7FFF_FFFF));
        lim = etfi_pkg::LIM_W'($urandom_range(0, 32'h7FFF_FFFF));
      end else begin
        cr = $urandom_range(0, 32'h3000_0000) - 32'h2000_0000;
        ci = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
        step = 31'(32'h3000_0000 / w) >> $urandom_range(0, 6);
        if (step == 0) step = 1;
        lim = etfi_pkg::ESC_LIM_RST;
      end
      iters = etfi_pkg::ITER_W'($urandom_range(1, 160));
      configure(cr, ci, step, w, h, iters, 1'($urandom_range(0, 1)), lim);
      if (phase == 0) hold_go <= 1'b1;
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          x = etfi_pkg::PIX_W'($urandom);
          y = etfi_pkg::PIX_W'($urandom);
        end else begin
          x = etfi_pkg::PIX_W'($urandom_range(0, w - 1));
          y = etfi_pkg::PIX_W'($urandom_range(0, h - 1));
        end
        send_pixel(x, y);
      end
      drain();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("tb_escape_time_fractal_iterator: PASS");
    else
      $display("tb_escape_time_fractal_iterator: FAIL");
    $finish;
  end

endmodule
